### src/assert_macros.svh
// Assertion macros for the RTL of the Hamming codec.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### src/hsec_pkg.sv
// Types, constants and geometry functions for the Hamming codec.
package hsec_pkg;

	localparam int WordW              = 63;
	localparam int SynW               = 6;
	localparam int LenW               = 6;
	localparam int MaxCodeBitsDefault = 63;
	localparam logic [LenW-1:0] ResetMsgBits = 6'd4;

	typedef enum logic {
		ACT_ENCODE = 1'b0,
		ACT_CHECK  = 1'b1
	} action_t;

	typedef struct packed {
		logic [WordW-1:0] word;
		logic [SynW-1:0]  syndrome;
		logic             corrected;
		logic             invalid;
	} hsec_result_t;

	// Parity count for a message length: least r with 2^r >= m + r + 1.
	function automatic logic [2:0] parity_count(input logic [LenW-1:0] m);
		logic [2:0] r;
		if (m <= 6'd1)       r = 3'd2;
		else if (m <= 6'd4)  r = 3'd3;
		else if (m <= 6'd11) r = 3'd4;
		else if (m <= 6'd26) r = 3'd5;
		else if (m <= 6'd57) r = 3'd6;
		else                 r = 3'd7;
		return r;
	endfunction

	// Largest message length whose codeword fits in max_bits positions.
	function automatic int max_msg_bits(input int max_bits);
		int res;
		res = 1;
		for (int m = 1; m < 64; m++) begin
			if (m + int'(parity_count(LenW'(m))) <= max_bits) res = m;
		end
		return res;
	endfunction

	// Codeword length for a register value, after the zero and size clamps.
	function automatic logic [LenW-1:0] code_len(input logic [LenW-1:0] value,
			input logic [LenW-1:0] max_m);
		logic [LenW-1:0] m;
		logic [LenW:0]   n;
		m = (value == '0) ? LenW'(1) : value;
		if (m > max_m) m = max_m;
		n = {1'b0, m} + (LenW+1)'(parity_count(m));
		return n[LenW-1:0];
	endfunction

	// Mask with the low n codeword positions set.
	function automatic logic [WordW-1:0] len_mask(input logic [LenW-1:0] n);
		return {WordW{1'b1}} >> (WordW - int'(n));
	endfunction

	function automatic logic is_pow2(input int p);
		return (p != 0) && ((p & (p - 1)) == 0);
	endfunction

	// Message bit index carried by a non-power-of-two position p.
	function automatic int msg_index(input int p);
		int pw;
		pw = 0;
		for (int t = 0; t < SynW; t++) begin
			if ((1 << t) <= p) pw++;
		end
		return p - 1 - pw;
	endfunction

	// Positions whose index has bit t set, as a bit vector (position p at bit p-1).
	function automatic logic [WordW-1:0] syn_cover(input int t);
		logic [WordW-1:0] v;
		v = '0;
		for (int p = 1; p <= WordW; p++) begin
			v[p-1] = ((p >> t) & 1) != 0;
		end
		return v;
	endfunction

endpackage

### src/hamming_sec_encode_correct.sv
// Top level of the Hamming single-error-correcting codec.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------------
//   in      | to block  | in_valid / in_stall    | action, word
//   out     | from block| out_valid / out_stall  | result_word, syndrome,
//           |           |                        | error_corrected, syndrome_invalid
//   cfg     | to block  | cfg_wr_en              | cfg_wr_data (message length)
//
// One word per cycle unless stalled: an input register, one pass of XOR trees, then the
// result register, which holds a result while the output is stalled.
// Reset clears both stage valids and loads the message length of four.
// A stalled result holds; the input register still takes a word while it is empty.
module hamming_sec_encode_correct #(
	parameter int MAX_CODE_BITS = hsec_pkg::MaxCodeBitsDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [hsec_pkg::LenW-1:0]         cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [hsec_pkg::WordW-1:0]        word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [hsec_pkg::WordW-1:0]        result_word,
	output logic [hsec_pkg::SynW-1:0]         syndrome,
	output logic                              error_corrected,
	output logic                              syndrome_invalid
);
	import hsec_pkg::*;

	`include "assert_macros.svh"

	localparam logic [LenW-1:0] MaxM   = LenW'(max_msg_bits(MAX_CODE_BITS));
	localparam logic [LenW-1:0] ResetN = code_len(ResetMsgBits, MaxM);

	logic [LenW-1:0]  code_n_q;
	logic [WordW-1:0] code_mask_q;
	logic             valid_s1;
	logic             action_s1;
	logic [WordW-1:0] word_s1;
	logic             hold_s2;
	logic             load_s1;
	hsec_result_t     res;

	// Geometry follows each register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_n_q    <= ResetN;
			code_mask_q <= len_mask(ResetN);
		end else if (cfg_wr_en) begin
			code_n_q    <= code_len(cfg_wr_data, MaxM);
			code_mask_q <= len_mask(code_len(cfg_wr_data, MaxM));
		end
	end

	// Stall the input only when both stages are full and the output is stalled.
	assign hold_s2  = out_valid && out_stall;
	assign in_stall = valid_s1 && hold_s2;
	assign load_s1  = in_valid && !in_stall;

	// Input stage: take a transfer, drop it once it moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (!hold_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			action_s1 <= action;
			word_s1   <= word;
		end
	end

	hsec_codec u_codec (
		.action    (action_s1),
		.word      (word_s1),
		.code_n    (code_n_q),
		.code_mask (code_mask_q),
		.result    (res)
	);

	// Result stage: hold while stalled, otherwise advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!hold_s2) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_s2 && valid_s1) begin
			result_word      <= res.word;
			syndrome         <= res.syndrome;
			error_corrected  <= res.corrected;
			syndrome_invalid <= res.invalid;
		end
	end

	`ASSERT_NEVER(a_flag_excl, clk, arst_n, out_valid && error_corrected && syndrome_invalid,
		"correction and invalid syndrome flagged together")
	`ASSERT_PROP(a_corr_syn, clk, arst_n,
		(out_valid && error_corrected) |-> (syndrome != '0 && syndrome <= code_n_q),
		"correction flagged with a syndrome outside the codeword")
	`ASSERT_NEVER(a_word_mask, clk, arst_n, out_valid && ((result_word & ~code_mask_q) != '0),
		"result word has bits past the codeword length")
	`ASSERT_PROP(a_load_s1, clk, arst_n, load_s1 |=> valid_s1,
		"accepted word missing from the input stage")
	`ASSERT_PROP(a_stall_full, clk, arst_n, in_stall |-> (valid_s1 && out_valid),
		"input stalled while a stage is empty")

endmodule

### src/hsec_codec.sv
// Single-pass Hamming encode and check/correct logic for one word.
module hsec_codec (
	input  logic                                    action,
	input  logic [hsec_pkg::WordW-1:0]              word,
	input  logic [hsec_pkg::LenW-1:0]               code_n,
	input  logic [hsec_pkg::WordW-1:0]              code_mask,
	output hsec_pkg::hsec_result_t                  result
);
	import hsec_pkg::*;

	logic [WordW-1:0] spread;
	logic [WordW-1:0] cw_in;
	logic [SynW-1:0]  syn;
	logic [WordW-1:0] parity_bits;
	logic [WordW-1:0] flip;
	logic             syn_over;
	logic             syn_hit;

	// Place message bits at the non-power-of-two positions.
	always_comb begin
		spread = '0;
		for (int p = 1; p <= WordW; p++) begin
			if (!is_pow2(p)) spread[p-1] = word[msg_index(p)];
		end
	end

	// Pick the word to code and drop positions past the codeword length.
	assign cw_in = ((action == ACT_CHECK) ? word : spread) & code_mask;

	// Syndrome: XOR of the indexes of all set positions.
	always_comb begin
		for (int t = 0; t < SynW; t++) begin
			syn[t] = ^(cw_in & syn_cover(t));
		end
	end

	// Parity bits sit at the power-of-two positions.
	always_comb begin
		parity_bits = '0;
		for (int t = 0; t < SynW; t++) begin
			parity_bits[(1 << t) - 1] = syn[t];
		end
	end

	assign syn_over = syn > code_n;
	assign syn_hit  = (syn != '0) && !syn_over;
	assign flip     = syn_hit ? (WordW'(1) << (syn - SynW'(1))) : '0;

	// Build the result for either action.
	always_comb begin
		if (action == ACT_CHECK) begin
			result.word      = cw_in ^ flip;
			result.syndrome  = syn;
			result.corrected = syn_hit;
			result.invalid   = syn_over;
		end else begin
			result.word      = (cw_in | parity_bits) & code_mask;
			result.syndrome  = '0;
			result.corrected = 1'b0;
			result.invalid   = 1'b0;
		end
	end

endmodule

### sim/codec_monitor.sv
// Channel monitor for the Hamming codec: predicts every result and compares it.
`timescale 1ns / 100ps

module codec_monitor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [hsec_pkg::LenW-1:0]  cfg_wr_data,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       action,
	input  logic [hsec_pkg::WordW-1:0] word,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [hsec_pkg::WordW-1:0] result_word,
	input  logic [hsec_pkg::SynW-1:0]  syndrome,
	input  logic                       error_corrected,
	input  logic                       syndrome_invalid,
	output int                         fail_count,
	output int                         pending,
	output int                         words_in,
	output int                         results_seen,
	output int                         fixes_seen,
	output int                         flagged_seen,
	output logic [hsec_pkg::LenW-1:0]  code_len
);
	import hsec_pkg::*;

	localparam int ReportCap = 100;

	logic [LenW-1:0] msg_len;
	hsec_result_t    expected_codes[$];
	hsec_result_t    want;
	hsec_result_t    got;
	int              shape_m;
	int              shape_n;
	int              reports = 0;

	initial begin
		fail_count   = 0;
		pending      = 0;
		words_in     = 0;
		results_seen = 0;
		fixes_seen   = 0;
		flagged_seen = 0;
	end

	// Clamp the register value, then derive message length m and codeword length n.
	function automatic void code_shape(input logic [LenW-1:0] value, output int m,
			output int n);
		int r;
		m = (value == '0) ? 1 : int'(value);
		r = 0;
		forever begin
			r = 0;
			while ((1 << r) < m + r + 1) r++;
			if (m + r <= WordW || m <= 1) break;
			m--;
		end
		n = m + r;
	endfunction

	// XOR of the one-based positions of all set bits up to n.
	function automatic int position_xor(input logic [WordW-1:0] cw, input int n);
		int s;
		s = 0;
		for (int p = 1; p <= n; p++) begin
			if (cw[p-1]) s ^= p;
		end
		return s;
	endfunction

	// Encode a message or check and repair a received codeword.
	function automatic hsec_result_t hamming_result(input action_t act,
			input logic [WordW-1:0] w, input logic [LenW-1:0] len);
		hsec_result_t     res;
		int               m;
		int               n;
		int               j;
		int               s;
		logic [WordW-1:0] cw;
		logic [WordW-1:0] keep;
		code_shape(len, m, n);
		keep = '0;
		for (int p = 0; p < n; p++) keep[p] = 1'b1;
		res = '0;
		cw  = '0;
		if (act == ACT_ENCODE) begin
			// Scatter message bits over the non-power-of-two positions.
			j = 0;
			for (int p = 1; p <= n; p++) begin
				if ((p & (p - 1)) != 0) begin
					if (j < m && w[j]) cw[p-1] = 1'b1;
					j++;
				end
			end
			// Set each parity bit so that its group XORs to zero.
			s = position_xor(cw, n);
			for (int t = 0; (1 << t) <= n; t++) begin
				if (((s >> t) & 1) != 0) cw[(1 << t) - 1] = 1'b1;
			end
		end else begin
			cw = w & keep;
			s = position_xor(cw, n);
			res.syndrome = SynW'(s);
			if (s > n) begin
				res.invalid = 1'b1;
			end else if (s != 0) begin
				cw[s-1] = ~cw[s-1];
				res.corrected = 1'b1;
			end
		end
		res.word = cw & keep;
		return res;
	endfunction

	// Track the message length register.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len <= ResetMsgBits;
		end else if (cfg_wr_en) begin
			msg_len <= cfg_wr_data;
		end
	end

	// Expose the codeword length for stimulus shaping.
	always_comb begin
		code_shape(msg_len, shape_m, shape_n);
		code_len = LenW'(shape_n);
	end

	// Compare each output transfer, then queue the prediction for each input transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{result_word, syndrome, error_corrected, syndrome_invalid};
				results_seen++;
				if (error_corrected) fixes_seen++;
				if (syndrome_invalid) flagged_seen++;
				if (expected_codes.size() == 0) begin
					fail_count++;
					if (reports < ReportCap) begin
						$display("%0t: result with nothing expected: word %h syn %0d fix %0b bad %0b",
							$time, got.word, got.syndrome, got.corrected, got.invalid);
						reports++;
					end
				end else begin
					want = expected_codes.pop_front();
					if (got.word !== want.word || got.syndrome !== want.syndrome ||
							got.corrected !== want.corrected ||
							got.invalid !== want.invalid) begin
						fail_count++;
						if (reports < ReportCap) begin
							$display("%0t: mismatch: expected word %h syn %0d fix %0b bad %0b",
								$time, want.word, want.syndrome, want.corrected, want.invalid);
							$display("%0t:           actual   word %h syn %0d fix %0b bad %0b",
								$time, got.word, got.syndrome, got.corrected, got.invalid);
							reports++;
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_codes.push_back(hamming_result(action_t'(action), word, msg_len));
				words_in++;
			end
			pending = expected_codes.size();
		end
	end

endmodule

### sim/testbench.sv
// Top of the Hamming codec testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module testbench;
	import hsec_pkg::*;

	localparam int NumPhases     = 16;
	localparam int ItemsPerPhase = 47;
	localparam int IdleLimit     = 3000;
	localparam int SqueezeAt     = 300;
	localparam int SqueezeLen    = 250;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [LenW-1:0]  cfg_wr_data = '0;
	logic             in_valid    = 1'b0;
	logic             in_stall;
	action_t          action      = ACT_ENCODE;
	logic [WordW-1:0] word        = '0;
	logic             out_valid;
	logic             out_stall   = 1'b0;
	logic [WordW-1:0] result_word;
	logic [SynW-1:0]  syndrome;
	logic             error_corrected;
	logic             syndrome_invalid;

	int               fail_count;
	int               pending;
	int               words_in;
	int               results_seen;
	int               fixes_seen;
	int               flagged_seen;
	logic [LenW-1:0]  code_len;

	int               idle_cycles  = 0;
	bit               squeeze_done = 1'b0;
	int               stall_left   = 0;
	int               free_left    = 0;

	always #4 clk = ~clk;

	hamming_sec_encode_correct u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.word             (word),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_word      (result_word),
		.syndrome         (syndrome),
		.error_corrected  (error_corrected),
		.syndrome_invalid (syndrome_invalid)
	);

	codec_monitor u_monitor (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.word             (word),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_word      (result_word),
		.syndrome         (syndrome),
		.error_corrected  (error_corrected),
		.syndrome_invalid (syndrome_invalid),
		.fail_count       (fail_count),
		.pending          (pending),
		.words_in         (words_in),
		.results_seen     (results_seen),
		.fixes_seen       (fixes_seen),
		.flagged_seen     (flagged_seen),
		.code_len         (code_len)
	);

	// Mostly short pauses, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// Length of a stretch without receiver stalls.
	function automatic int pick_run();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 6);
		if (r < 90) return $urandom_range(7, 30);
		return $urandom_range(100, 300);
	endfunction

	function automatic logic [WordW-1:0] rand_word();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return WordW'({$urandom, $urandom});
	endfunction

	// Build a received word: mostly clean codewords or one-bit errors, some raw noise.
	function automatic logic [WordW-1:0] check_word(input int n);
		logic [WordW-1:0] w;
		int               s;
		int               q;
		int               kind;
		w = rand_word();
		kind = $urandom_range(0, 9);
		if (kind < 8) begin
			s = 0;
			for (int p = 1; p <= n; p++) begin
				if (w[p-1]) s ^= p;
			end
			// Pull the syndrome into range, then flip it away to land on a codeword.
			while (s > n) begin
				q = $urandom_range(1, n);
				w[q-1] = ~w[q-1];
				s ^= q;
			end
			if (s != 0) w[s-1] = ~w[s-1];
			// Add one error to about half of them.
			if (kind >= 4) begin
				q = $urandom_range(1, n);
				w[q-1] = ~w[q-1];
			end
		end
		return w;
	endfunction

	// Offer one word after an optional gap and hold it until the transfer.
	task automatic send_item(input action_t act, input logic [WordW-1:0] w,
			input bit steady);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		word     <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Write the message length once the pipeline has drained.
	task automatic set_msg_len(input logic [LenW-1:0] value);
		while (pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Stimulus: reset, then one phase per message length.
	initial begin
		logic [LenW-1:0]  plan [NumPhases];
		logic [WordW-1:0] good;
		bit               steady;
		plan = '{6'd4, 6'd5, 6'd0, 6'd1, 6'd2, 6'd3, 6'd11, 6'd12,
			6'd26, 6'd27, 6'd56, 6'd57, 6'd58, 6'd63, 6'd0, 6'd0};
		plan[14] = LenW'($urandom_range(0, 63));
		plan[15] = LenW'($urandom_range(0, 63));
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int phase = 0; phase < NumPhases; phase++) begin
			// The first phase runs at the reset length of four.
			if (phase > 0) set_msg_len(plan[phase]);
			steady = ($urandom_range(0, 3) == 0);
			if (phase == 0) begin
				send_item(ACT_ENCODE, '0, 1'b0);
				send_item(ACT_ENCODE, '1, 1'b0);
				send_item(ACT_CHECK, '0, 1'b0);
				send_item(ACT_CHECK, '1, 1'b0);
				// Clean (7,4) codeword for message 1011, then each single-bit error.
				good = 63'h55;
				send_item(ACT_CHECK, good, 1'b0);
				for (int k = 0; k < 7; k++) send_item(ACT_CHECK, good ^ (63'd1 << k), 1'b0);
			end
			if (phase == 1) begin
				// Syndrome past the nine-bit codeword, then an all-ones word.
				send_item(ACT_CHECK, 63'h140, 1'b0);
				send_item(ACT_CHECK, 63'h1ff, 1'b0);
			end
			repeat (ItemsPerPhase) begin
				if ($urandom_range(0, 99) < 35) send_item(ACT_ENCODE, rand_word(), steady);
				else send_item(ACT_CHECK, check_word(int'(code_len)), steady);
			end
			in_valid <= 1'b0;
			@(negedge clk);
		end

		// Drain the pipeline and let the latency pass.
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		$display("Sent %0d words across %0d message length settings, zero and oversize included.",
			words_in, NumPhases);
		$display("Compared %0d results: %0d single-bit repairs, %0d out-of-range syndromes.",
			results_seen, fixes_seen, flagged_seen);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off while the sender keeps offering.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!squeeze_done && words_in >= SqueezeAt && in_valid) begin
				squeeze_done = 1'b1;
				stall_left   = SqueezeLen;
				free_left    = 0;
			end else if (stall_left == 0 && free_left == 0) begin
				stall_left = pick_gap();
				free_left  = pick_run();
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				free_left--;
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("%0t: no transfer for %0d cycles, giving up", $time, IdleLimit);
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

### hamming_sec_encode_correct.f
+incdir+src
src/hsec_pkg.sv
src/hsec_codec.sv
src/hamming_sec_encode_correct.sv
sim/codec_monitor.sv
sim/testbench.sv
